@@ sv/rtcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types, limits and the month length table of the clock/calendar core.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcc_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_TIME = 2'd1,
    MODE_DATE = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam int unsigned TPS_W = 8;
  localparam int unsigned FIELDS_W = 40;

  localparam logic [TPS_W-1:0] TPS_RESET = 8'd60;
  localparam logic [5:0] SEC_LIMIT = 6'd60;
  localparam logic [5:0] MIN_LIMIT = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;
  localparam logic [3:0] MONTH_LIMIT = 4'd13;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // time and date fields, hours in the lowest bits
  typedef struct packed {
    logic [13:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } fields_t;

  // counter state of the clock
  typedef struct packed {
    logic [TPS_W-1:0] prescale;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [13:0] year;
  } clock_state_t;

  // days in a month; zero and thirteen to fifteen count as long months
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2: len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ sv/rtcc_next.sv @@
// ----------------------------------------------------------------------------
// rtcc_next
// Next counter state for one item: prescaler, time carry chain, calendar.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcc_next (
  input  var rtcc_pkg::clock_state_t cur,
  input  wire logic [rtcc_pkg::TPS_W-1:0] tps,
  input  var rtcc_pkg::mode_t mode,
  input  var rtcc_pkg::fields_t load,
  output rtcc_pkg::clock_state_t nxt
);

  always_comb begin
    logic [rtcc_pkg::TPS_W:0] p;
    logic [6:0] s_sec;
    logic [6:0] s_min;
    logic [5:0] s_hour;
    logic [5:0] d;
    logic [5:0] len;
    logic day_carry;

    nxt = cur;
    p = {1'b0, cur.prescale} + {{rtcc_pkg::TPS_W{1'b0}}, 1'b1};
    s_sec = {1'b0, cur.sec} + 7'd1;
    s_min = {1'b0, cur.min} + 7'd1;
    s_hour = {1'b0, cur.hour} + 6'd1;
    d = {1'b0, cur.day} + 6'd1;
    len = {1'b0, rtcc_pkg::month_len(cur.month)};
    day_carry = 1'b0;

    case (mode)
      rtcc_pkg::MODE_TICK: begin
        // prescaler, then seconds, minutes and hours
        if (p >= {1'b0, tps}) begin
          nxt.prescale = '0;
          if (s_sec < {1'b0, rtcc_pkg::SEC_LIMIT}) begin
            nxt.sec = s_sec[5:0];
          end else begin
            nxt.sec = '0;
            if (s_min < {1'b0, rtcc_pkg::MIN_LIMIT}) begin
              nxt.min = s_min[5:0];
            end else begin
              nxt.min = '0;
              if (s_hour < {1'b0, rtcc_pkg::HOUR_LIMIT}) begin
                nxt.hour = s_hour[4:0];
              end else begin
                nxt.hour = '0;
                day_carry = 1'b1;
              end
            end
          end
        end else begin
          nxt.prescale = p[rtcc_pkg::TPS_W-1:0];
        end
        // day of month rolls into the month
        if (day_carry) begin
          if (d >= len + 6'd1) begin
            nxt.day = 5'd1;
            nxt.month = cur.month + 4'd1;
          end else begin
            nxt.day = d[4:0];
          end
        end
        // month past december rolls into the year
        if (nxt.month >= rtcc_pkg::MONTH_LIMIT) begin
          nxt.month = 4'd1;
          if (cur.year >= rtcc_pkg::YEAR_MAX) begin
            nxt.year = '0;
          end else begin
            nxt.year = cur.year + 14'd1;
          end
        end
      end
      rtcc_pkg::MODE_TIME: begin
        nxt.hour = load.hours;
        nxt.min = load.minutes;
        nxt.sec = load.seconds;
      end
      rtcc_pkg::MODE_DATE: begin
        nxt.day = load.day;
        nxt.month = load.month;
        nxt.year = load.year;
      end
      default: begin
        // ignored item, state holds
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/calendar_clock_counter_core.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_counter_core
// Real-time clock and calendar driven by tick, time load and date load items.
// ----------------------------------------------------------------------------
// Stages: input register, then next-state logic into the counters and the
//   result register.
// Throughput: one item per cycle unless m_tready stalls the result register.
// Reset (rst, synchronous): time 00:00:00, day 1, month 1, year 0, prescaler
//   cleared, ticks_per_second 60, both stages empty.
`default_nettype none

module calendar_clock_counter_core (
  input  wire logic clk,
  input  wire logic rst,
  // configuration: ticks_per_second
  input  wire logic cfg_we,
  input  wire logic [rtcc_pkg::TPS_W-1:0] cfg_wdata,
  // input items
  input  wire logic s_tvalid,
  output logic s_tready,
  // set_hours, set_minutes, set_seconds, set_day, set_month, set_year
  input  wire logic [rtcc_pkg::FIELDS_W-1:0] s_tdata,
  // mode
  input  wire logic [1:0] s_tuser,
  // result items
  output logic m_tvalid,
  input  wire logic m_tready,
  // hours, minutes, seconds, day, month, year
  output logic [rtcc_pkg::FIELDS_W-1:0] m_tdata
);

  logic [rtcc_pkg::TPS_W-1:0] tps;
  logic in_valid;
  rtcc_pkg::mode_t in_mode;
  rtcc_pkg::fields_t in_load;
  rtcc_pkg::clock_state_t state;
  rtcc_pkg::clock_state_t state_next;
  rtcc_pkg::fields_t out_data;
  logic adv;
  logic fire;

  // result register free, input stage moves on
  assign adv = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;
  assign fire = in_valid && adv;

  rtcc_next u_next (
    .cur  (state),
    .tps  (tps),
    .mode (in_mode),
    .load (in_load),
    .nxt  (state_next)
  );

  // control and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= rtcc_pkg::TPS_RESET;
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      state <= '{prescale: '0, sec: '0, min: '0, hour: '0,
                 day: 5'd1, month: 4'd1, year: '0};
    end else begin
      if (cfg_we) begin
        tps <= cfg_wdata;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= rtcc_pkg::mode_t'(s_tuser);
      in_load <= rtcc_pkg::fields_t'(s_tdata);
    end
    if (fire) begin
      out_data.hours <= state_next.hour;
      out_data.minutes <= state_next.min;
      out_data.seconds <= state_next.sec;
      out_data.day <= state_next.day;
      out_data.month <= state_next.month;
      out_data.year <= state_next.year;
    end
  end

  assign m_tdata = out_data;

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a time load shows up unchanged in the result
  a_time_load: assert property (@(posedge clk) disable iff (rst)
    (fire && in_mode == rtcc_pkg::MODE_TIME) |=>
      (out_data.seconds == $past(in_load.seconds) &&
       out_data.minutes == $past(in_load.minutes) &&
       out_data.hours == $past(in_load.hours)))
    else $error("time load not reflected in result");

  // after a tick the prescaler stays below the configured count
  a_prescale_range: assert property (@(posedge clk) disable iff (rst)
    (fire && in_mode == rtcc_pkg::MODE_TICK && !cfg_we) |=>
      (state.prescale == '0 || state.prescale < tps))
    else $error("prescaler out of range after tick");

  // a tick never leaves a month past december
  a_month_wrap: assert property (@(posedge clk) disable iff (rst)
    (fire && in_mode == rtcc_pkg::MODE_TICK) |=>
      (state.month < rtcc_pkg::MONTH_LIMIT))
    else $error("month not wrapped after tick");

endmodule

`default_nettype wire
